@@ design/slab_pkg.sv @@
// ---------------------------------------------------------------------------
// slab_pkg
// shared types, register map and arithmetic helpers of the layer blender
// ---------------------------------------------------------------------------
`default_nettype none

package slab_pkg;

   // item opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_BLEND = 1'b1;

   // register map, index = paddr[4:2]
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_IDX_W  = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LAYER_WIDTH  = 3'd0,
      REG_LAYER_HEIGHT = 3'd1,
      REG_IMAGE_WIDTH  = 3'd2,
      REG_IMAGE_HEIGHT = 3'd3,
      REG_OPACITY      = 3'd4,
      REG_USE_IMAGE    = 3'd5,
      REG_FILL_COLOR   = 3'd6
   } reg_index_type;

   // field widths
   localparam int unsigned LAYER_DIM_W = 13;
   localparam int unsigned IMAGE_DIM_W = 9;
   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned RGBA_W      = 32;
   localparam int unsigned INDEX_W     = 16;

   // image side limit, quotient of the scaling divide stays below it
   localparam logic [IMAGE_DIM_W-1:0] IMAGE_SIDE_MAX = 9'd256;
   localparam int unsigned QUOT_W    = 8;
   localparam int unsigned QSTEP_W   = 3;
   localparam int unsigned SUM_W     = 17;
   localparam int unsigned SAMPLE_W  = 17;
   localparam logic [SUM_W-1:0] ROUND_HALF = 17'd127;
   localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;

   // x / 255 for x below 65280, as reciprocal multiply with correction
   function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] x);
      logic [SUM_W-1:0] t;
      t = x + 17'd1 + (x >> 8);
      return t[15:8];
   endfunction

endpackage

`default_nettype wire

@@ design/slab_ram.sv @@
// ---------------------------------------------------------------------------
// slab_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module slab_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/scaled_layer_alpha_blend.sv @@
// ---------------------------------------------------------------------------
// scaled_layer_alpha_blend
// layer compositor: nearest-neighbor scaled texel or fill color, opacity
// scaled alpha, source-over blend onto the canvas pixel stream
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  op, texel_index, texel_rgba,
//                                             canvas_rgba
//   rsp       out        rsp_valid/rsp_ready  blended_rgba, end_of_layer
//   csr       in/out     apb, pready high     pwdata/prdata, 7 registers
//
// a load word writes the texel ram at acceptance; the sequencer stays idle
// a blend word runs through these steps in order: the multiply at
// acceptance, the bit-serial scaling divider (x and y side by side),
// address multiply, ram read, alpha, mix; mix waits until the output
// register is free, loads it and returns the sequencer to idle
// req_ready is high only while the sequencer is idle; a finished result
// waits in the output register, loads and blends are still taken behind it
// reset is synchronous; the texel ram is not cleared and needs no sweep
// ---------------------------------------------------------------------------
`default_nettype none

module scaled_layer_alpha_blend #(
   parameter int unsigned TEXEL_COUNT = 65536,
   parameter int unsigned MAX_SIDE    = 4096
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request words
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_op,
   input  wire logic [slab_pkg::INDEX_W-1:0]           req_texel_index,
   input  wire logic [slab_pkg::RGBA_W-1:0]            req_texel_rgba,
   input  wire logic [slab_pkg::RGBA_W-1:0]            req_canvas_rgba,
   // response words
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic      [slab_pkg::RGBA_W-1:0]            rsp_blended_rgba,
   output logic                                        rsp_end_of_layer,
   // register port
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [slab_pkg::CSR_ADDR_W-1:0]        paddr,
   input  wire logic [slab_pkg::RGBA_W-1:0]            pwdata,
   output logic      [slab_pkg::RGBA_W-1:0]            prdata,
   output logic                                        pready
);

   // counter width and the width used for dimension compares
   localparam int unsigned CNT_W  = $clog2(MAX_SIDE);
   localparam int unsigned DIM_W  = (CNT_W + 1 > slab_pkg::LAYER_DIM_W) ?
                                    CNT_W + 1 : slab_pkg::LAYER_DIM_W;
   localparam int unsigned NUM_W  = CNT_W + slab_pkg::IMAGE_DIM_W;
   localparam int unsigned REM_W  = DIM_W + slab_pkg::IMAGE_DIM_W;
   localparam int unsigned ADDR_W = $clog2(TEXEL_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ADDR,
      ST_READ,
      ST_ALPHA,
      ST_MIX
   } state_type;

   // -------------------------------------------------------------------
   // configuration registers
   // -------------------------------------------------------------------
   logic [slab_pkg::LAYER_DIM_W-1:0] layer_width_ff, layer_height_ff;
   logic [slab_pkg::IMAGE_DIM_W-1:0] image_width_ff, image_height_ff;
   logic [slab_pkg::CHAN_W-1:0]      opacity_ff;
   logic                             use_image_ff;
   logic [slab_pkg::RGBA_W-1:0]      fill_color_ff;
   logic                             csr_write;
   logic [slab_pkg::CSR_IDX_W-1:0]   csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = paddr[slab_pkg::CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_width_ff  <= slab_pkg::LAYER_DIM_W'(1);
         layer_height_ff <= slab_pkg::LAYER_DIM_W'(1);
         image_width_ff  <= slab_pkg::IMAGE_DIM_W'(1);
         image_height_ff <= slab_pkg::IMAGE_DIM_W'(1);
         opacity_ff      <= slab_pkg::CHAN_MAX;
         use_image_ff    <= 1'b0;
         fill_color_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            slab_pkg::REG_LAYER_WIDTH:  layer_width_ff  <= pwdata[slab_pkg::LAYER_DIM_W-1:0];
            slab_pkg::REG_LAYER_HEIGHT: layer_height_ff <= pwdata[slab_pkg::LAYER_DIM_W-1:0];
            slab_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[slab_pkg::IMAGE_DIM_W-1:0];
            slab_pkg::REG_IMAGE_HEIGHT: image_height_ff <= pwdata[slab_pkg::IMAGE_DIM_W-1:0];
            slab_pkg::REG_OPACITY:      opacity_ff      <= pwdata[slab_pkg::CHAN_W-1:0];
            slab_pkg::REG_USE_IMAGE:    use_image_ff    <= pwdata[0];
            slab_pkg::REG_FILL_COLOR:   fill_color_ff   <= pwdata;
            default: ;  // beyond the register list
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         slab_pkg::REG_LAYER_WIDTH:  prdata = slab_pkg::RGBA_W'(layer_width_ff);
         slab_pkg::REG_LAYER_HEIGHT: prdata = slab_pkg::RGBA_W'(layer_height_ff);
         slab_pkg::REG_IMAGE_WIDTH:  prdata = slab_pkg::RGBA_W'(image_width_ff);
         slab_pkg::REG_IMAGE_HEIGHT: prdata = slab_pkg::RGBA_W'(image_height_ff);
         slab_pkg::REG_OPACITY:      prdata = slab_pkg::RGBA_W'(opacity_ff);
         slab_pkg::REG_USE_IMAGE:    prdata = slab_pkg::RGBA_W'(use_image_ff);
         slab_pkg::REG_FILL_COLOR:   prdata = fill_color_ff;
         default:                    prdata = '0;
      endcase
   end

   // -------------------------------------------------------------------
   // effective dimensions: zero reads as one, oversize is clamped
   // -------------------------------------------------------------------
   logic [DIM_W-1:0]                 lw, lh;
   logic [slab_pkg::IMAGE_DIM_W-1:0] iw, ih;

   always_comb begin
      lw = DIM_W'(layer_width_ff);
      if (lw == '0) lw = DIM_W'(1);
      else if (lw > DIM_W'(MAX_SIDE)) lw = DIM_W'(MAX_SIDE);
      lh = DIM_W'(layer_height_ff);
      if (lh == '0) lh = DIM_W'(1);
      else if (lh > DIM_W'(MAX_SIDE)) lh = DIM_W'(MAX_SIDE);
      iw = image_width_ff;
      if (iw == '0) iw = slab_pkg::IMAGE_DIM_W'(1);
      else if (iw > slab_pkg::IMAGE_SIDE_MAX) iw = slab_pkg::IMAGE_SIDE_MAX;
      ih = image_height_ff;
      if (ih == '0) ih = slab_pkg::IMAGE_DIM_W'(1);
      else if (ih > slab_pkg::IMAGE_SIDE_MAX) ih = slab_pkg::IMAGE_SIDE_MAX;
   end

   // -------------------------------------------------------------------
   // raster counters, advanced at acceptance of a blend word
   // -------------------------------------------------------------------
   state_type          state_ff;
   logic [CNT_W-1:0]   col_ff, row_ff, col_in, row_in;
   logic [CNT_W-1:0]   col_cur, row_cur;
   logic [CNT_W:0]     col_inc, row_inc;
   logic               end_in;
   logic               req_take, blend_take, load_take;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_valid & req_ready;
   assign blend_take = req_take & (req_op == slab_pkg::OP_BLEND);
   assign load_take  = req_take & (req_op == slab_pkg::OP_LOAD);

   always_comb begin
      // counters left beyond a shrunken rectangle restart at zero
      col_cur = (DIM_W'(col_ff) >= lw) ? '0 : col_ff;
      row_cur = (DIM_W'(row_ff) >= lh) ? '0 : row_ff;
      col_inc = {1'b0, col_cur} + (CNT_W+1)'(1);
      row_inc = {1'b0, row_cur} + (CNT_W+1)'(1);
      col_in  = col_inc[CNT_W-1:0];
      row_in  = row_cur;
      end_in  = 1'b0;
      if (DIM_W'(col_inc) >= lw) begin
         col_in = '0;
         row_in = row_inc[CNT_W-1:0];
         if (DIM_W'(row_inc) >= lh) begin
            row_in = '0;
            end_in = 1'b1;
         end
      end
   end

   // -------------------------------------------------------------------
   // texel ram: loads write at acceptance, blends read one address
   // -------------------------------------------------------------------
   logic                        ram_wr_en;
   logic [slab_pkg::RGBA_W-1:0] ram_rd_data;
   logic [slab_pkg::SAMPLE_W-1:0] addr_ff;
   logic                        in_range_ff;

   assign ram_wr_en = load_take &
                      (32'(req_texel_index) < 32'(TEXEL_COUNT));

   slab_ram #(
      .WIDTH (slab_pkg::RGBA_W),
      .DEPTH (TEXEL_COUNT)
   ) u_texel_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_W'(req_texel_index)),
      .wr_data (req_texel_rgba),
      .rd_addr (ADDR_W'(addr_ff)),
      .rd_data (ram_rd_data)
   );

   // -------------------------------------------------------------------
   // datapath
   // -------------------------------------------------------------------
   // bit-serial restoring divide, quotient known to stay below 256
   logic [REM_W-1:0]              remx_ff, remy_ff, dvx_ff, dvy_ff;
   logic [slab_pkg::QUOT_W-1:0]   qx_ff, qy_ff;
   logic [slab_pkg::QSTEP_W-1:0]  step_ff;
   logic                          x_fits, y_fits;
   logic [slab_pkg::RGBA_W-1:0]   canvas_ff, src_ff, src_sel;
   logic [slab_pkg::CHAN_W-1:0]   sa_ff, inv;
   logic                          end_ff;
   logic [slab_pkg::RGBA_W-1:0]   mix;
   logic [slab_pkg::CHAN_W-1:0]   s_ch, d_ch, alpha_tail;
   logic [slab_pkg::SAMPLE_W-1:0] addr_in;
   logic                          rsp_valid_ff, rsp_end_ff;
   logic [slab_pkg::RGBA_W-1:0]   rsp_rgba_ff;
   logic                          rsp_free;
   logic                          rsp_load;

   assign x_fits   = (remx_ff >= dvx_ff);
   assign y_fits   = (remy_ff >= dvy_ff);
   assign addr_in  = slab_pkg::SAMPLE_W'(qy_ff * iw) + slab_pkg::SAMPLE_W'(qx_ff);
   assign rsp_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_load = (state_ff == ST_MIX) & rsp_free;

   // source word: sampled texel (zero beyond the ram) or fill color
   assign src_sel = use_image_ff ? (in_range_ff ? ram_rd_data : '0) : fill_color_ff;

   // per-channel source-over, alpha keeps scaled source plus faded canvas
   always_comb begin
      inv = slab_pkg::CHAN_MAX - sa_ff;
      mix = '0;
      for (int ch = 1; ch < 4; ch++) begin
         s_ch = src_ff[ch*8 +: 8];
         d_ch = canvas_ff[ch*8 +: 8];
         mix[ch*8 +: 8] = slab_pkg::div255(slab_pkg::SUM_W'(s_ch * sa_ff) +
                                           slab_pkg::SUM_W'(d_ch * inv) +
                                           slab_pkg::ROUND_HALF);
      end
      alpha_tail = slab_pkg::div255(slab_pkg::SUM_W'(canvas_ff[7:0] * inv) +
                                    slab_pkg::ROUND_HALF);
      mix[7:0]   = sa_ff + alpha_tail;
   end

   // output register: loaded from the mix stage, emptied when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (blend_take) begin
                  col_ff    <= col_in;
                  row_ff    <= row_in;
                  end_ff    <= end_in;
                  canvas_ff <= req_canvas_rgba;
                  // numerators col*iw and row*ih, divisors aligned to quotient msb
                  remx_ff   <= REM_W'(NUM_W'(col_cur) * NUM_W'(iw));
                  remy_ff   <= REM_W'(NUM_W'(row_cur) * NUM_W'(ih));
                  dvx_ff    <= REM_W'(lw) << (slab_pkg::QUOT_W - 1);
                  dvy_ff    <= REM_W'(lh) << (slab_pkg::QUOT_W - 1);
                  step_ff   <= slab_pkg::QSTEP_W'(slab_pkg::QUOT_W - 1);
                  state_ff  <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (x_fits) remx_ff <= remx_ff - dvx_ff;
               if (y_fits) remy_ff <= remy_ff - dvy_ff;
               qx_ff   <= {qx_ff[slab_pkg::QUOT_W-2:0], x_fits};
               qy_ff   <= {qy_ff[slab_pkg::QUOT_W-2:0], y_fits};
               dvx_ff  <= dvx_ff >> 1;
               dvy_ff  <= dvy_ff >> 1;
               step_ff <= step_ff - slab_pkg::QSTEP_W'(1);
               if (step_ff == '0) begin
                  state_ff <= ST_ADDR;
               end
            end
            ST_ADDR: begin
               addr_ff     <= addr_in;
               in_range_ff <= (32'(addr_in) < 32'(TEXEL_COUNT));
               state_ff    <= ST_READ;
            end
            ST_READ: begin
               // ram registers the texel this cycle
               state_ff <= ST_ALPHA;
            end
            ST_ALPHA: begin
               src_ff   <= src_sel;
               sa_ff    <= slab_pkg::div255(slab_pkg::SUM_W'(src_sel[7:0] * opacity_ff) +
                                            slab_pkg::ROUND_HALF);
               state_ff <= ST_MIX;
            end
            ST_MIX: begin
               if (rsp_free) begin
                  rsp_rgba_ff  <= mix;
                  rsp_end_ff   <= end_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_blended_rgba = rsp_rgba_ff;
   assign rsp_end_of_layer = rsp_end_ff;

endmodule

`default_nettype wire

@@ design/slab_checker.sv @@
// ---------------------------------------------------------------------------
// slab_checker
// port-level checks of the layer blender, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

module slab_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             req_op,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [slab_pkg::RGBA_W-1:0]      rsp_blended_rgba,
   input wire logic                             rsp_end_of_layer
);

   // a held result keeps its word until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blended_rgba) &&
                                  $stable(rsp_end_of_layer))
      else $error("response word changed while stalled");

   // a blend word occupies the sequencer for the next cycle
   a_blend_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == slab_pkg::OP_BLEND |=> !req_ready)
      else $error("request taken right after a blend word");

   // a load finishes in its accept cycle
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == slab_pkg::OP_LOAD |=> req_ready)
      else $error("load word stalled the request side");

   // reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind scaled_layer_alpha_blend slab_checker u_slab_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_op           (req_op),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_blended_rgba (rsp_blended_rgba),
   .rsp_end_of_layer (rsp_end_of_layer)
);

`default_nettype wire
